### hdl/crl_pkg.sv
// Shared types and constants for the Catmull-Rom line upsampler.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package crl_pkg;

   localparam int PIXEL_W          = 8;
   localparam int OUT_W            = 14;
   localparam int FACTOR_W         = 4;
   localparam int FACTOR_RESET     = 2;
   localparam int MAX_FACTOR       = 8;
   localparam int WEIGHT_FRAC_BITS = 15;
   localparam int TAP_COUNT        = 4;

   // Q1.15 weights lie within about -0.15..1.0, so two integer bits cover them
   localparam int WEIGHT_W    = WEIGHT_FRAC_BITS + 2;
   localparam int PROD_W      = WEIGHT_W + PIXEL_W + 1;
   localparam int ACC_W       = PROD_W + 2;
   localparam int OUT_SHIFT   = WEIGHT_FRAC_BITS - 4;
   localparam int SHIFT_W     = ACC_W - OUT_SHIFT;
   localparam int OUT_MIN     = -512;
   localparam int OUT_MAX     = 4607;

   localparam int PHASE_IDX_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
   localparam int PHASE_SPAN  = 1 << PHASE_IDX_W;
   localparam int ROM_IDX_W   = 2 * PHASE_IDX_W;
   localparam int ROM_DEPTH   = 1 << ROM_IDX_W;
   localparam int EFF_W       = $clog2(MAX_FACTOR + 1);

   // Which source position of the current input is being emitted
   typedef enum logic [1:0] {
      GRP_A,   // taps k-3..k
      GRP_B,   // taps k-2..k+1, right edge clamped
      GRP_C    // taps k-1..k+2, right edge clamped
   } grp_type;

   typedef struct packed {
      logic                   load;
      logic                   issue;
      grp_type                grp;
      logic [PHASE_IDX_W-1:0] phase;
      logic [PHASE_IDX_W-1:0] factor_idx;
      logic                   run_last;
      logic                   line_done;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] pos;
      logic       advance;
   } dp_sts_type;

   // Tap weight numerator over 2*r^3 at phase j/r; tap 0..3 = offsets -2..+1
   function automatic longint tap_num(longint j, longint r, int t);
      longint j2, j3, r2, r3, res;
      j2 = j * j;
      j3 = j2 * j;
      r2 = r * r;
      r3 = r2 * r;
      case (t)
         0:       res = -j3 + 2 * j2 * r - j * r2;
         1:       res = 3 * j3 - 5 * j2 * r + 2 * r3;
         2:       res = -3 * j3 + 4 * j2 * r + j * r2;
         default: res = j3 - j2 * r;
      endcase
      return res;
   endfunction

endpackage

### hdl/crl_req_if.sv
// Input channel of the upsampler: valid/ready plus one source pixel.
// Depends on crl_pkg.
interface crl_req_if;
   logic                        valid;
   logic                        ready;
   logic [crl_pkg::PIXEL_W-1:0] pixel_in;
   logic                        line_end;

   modport source (output valid, output pixel_in, output line_end, input ready);
   modport sink   (input valid, input pixel_in, input line_end, output ready);
endinterface

### hdl/crl_rsp_if.sv
// Result channel of the upsampler: valid/ready plus one interpolated sample.
// Depends on crl_pkg.
interface crl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [crl_pkg::OUT_W-1:0] pixel_out;
   logic                             run_last;
   logic                             line_done;

   modport source (output valid, output pixel_out, output run_last, output line_done,
                   input ready);
   modport sink   (input valid, input pixel_out, input run_last, input line_done,
                   output ready);
endinterface

### hdl/crl_datapath.sv
// Datapath: tap window, weight table and a two-stage multiply/accumulate pipeline
// whose second stage is the output register. Depends on crl_pkg; driven by crl_controller commands.
module crl_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [crl_pkg::PIXEL_W-1:0] pixel_in,
   input  logic                        line_end,
   input  crl_pkg::ctl_cmd_type        cmd,
   output crl_pkg::dp_sts_type         sts,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [crl_pkg::OUT_W-1:0] rsp_pixel_out,
   output logic                        rsp_run_last,
   output logic                        rsp_line_done
);

   localparam int WFB = crl_pkg::WEIGHT_FRAC_BITS;

   // window state, newest first
   logic [crl_pkg::PIXEL_W-1:0] win0_ff, win1_ff, win2_ff;
   logic [crl_pkg::PIXEL_W-1:0] win0_in, win1_in, win2_in;
   logic [1:0]                  pos_ff, pos_in;

   // snapshot of the taps of the item being emitted
   logic [crl_pkg::PIXEL_W-1:0] snap_ff [crl_pkg::TAP_COUNT];

   logic signed [crl_pkg::WEIGHT_W-1:0] weight_rom [crl_pkg::ROM_DEPTH][crl_pkg::TAP_COUNT];
   logic [crl_pkg::ROM_IDX_W-1:0]       rom_idx;
   logic [crl_pkg::PIXEL_W-1:0]         tap_sel [crl_pkg::TAP_COUNT];

   logic                              s1_valid_ff, s1_last_ff, s1_done_ff;
   logic signed [crl_pkg::PROD_W-1:0] prod_ff [crl_pkg::TAP_COUNT];

   logic                              out_valid_ff, out_last_ff, out_done_ff;
   logic signed [crl_pkg::OUT_W-1:0]  out_pixel_ff;

   logic                               advance;
   logic signed [crl_pkg::ACC_W-1:0]   acc_sum;
   logic signed [crl_pkg::SHIFT_W-1:0] acc_shift;
   logic signed [crl_pkg::OUT_W-1:0]   pixel_sat;

   // Weight table, worked out at elaboration: round to nearest, ties away from zero
   for (genvar gr = 0; gr < crl_pkg::PHASE_SPAN; gr++) begin : g_r
      for (genvar gj = 0; gj < crl_pkg::PHASE_SPAN; gj++) begin : g_j
         for (genvar gt = 0; gt < crl_pkg::TAP_COUNT; gt++) begin : g_t
            localparam longint Scaled = crl_pkg::tap_num(gj + 1, gr + 1, gt)
                                        * (longint'(1) << WFB);
            localparam longint Den    = 2 * (gr + 1) * (gr + 1) * (gr + 1);
            localparam longint Mag    = (Scaled < 0) ? -Scaled : Scaled;
            localparam longint Quo    = (Mag + Den / 2) / Den;
            localparam longint Wt     = (gj <= gr && gr < crl_pkg::MAX_FACTOR)
                                        ? ((Scaled < 0) ? -Quo : Quo) : 0;
            assign weight_rom[gr * crl_pkg::PHASE_SPAN + gj][gt] = Wt[crl_pkg::WEIGHT_W-1:0];
         end
      end
   end

   assign advance = !out_valid_ff || rsp_ready;
   assign sts.advance = advance;
   assign sts.pos     = pos_ff;

   // first pixel of a line fills the window, clamping the left edge
   always_comb begin
      if (pos_ff == 2'd0) begin
         win0_in = pixel_in;
         win1_in = pixel_in;
         win2_in = pixel_in;
      end else begin
         win0_in = win0_ff;
         win1_in = win1_ff;
         win2_in = win2_ff;
      end
      if (line_end) begin
         pos_in = 2'd0;
      end else if (pos_ff < 2'd2) begin
         pos_in = pos_ff + 2'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   // right-edge clamp: taps past the newest pixel repeat it
   always_comb begin
      case (cmd.grp)
         crl_pkg::GRP_A: begin
            tap_sel[0] = snap_ff[0];
            tap_sel[1] = snap_ff[1];
            tap_sel[2] = snap_ff[2];
            tap_sel[3] = snap_ff[3];
         end
         crl_pkg::GRP_B: begin
            tap_sel[0] = snap_ff[1];
            tap_sel[1] = snap_ff[2];
            tap_sel[2] = snap_ff[3];
            tap_sel[3] = snap_ff[3];
         end
         default: begin
            tap_sel[0] = snap_ff[2];
            tap_sel[1] = snap_ff[3];
            tap_sel[2] = snap_ff[3];
            tap_sel[3] = snap_ff[3];
         end
      endcase
   end

   assign rom_idx = {cmd.factor_idx, cmd.phase};

   always_comb begin
      acc_sum = crl_pkg::ACC_W'(prod_ff[0]) + crl_pkg::ACC_W'(prod_ff[1])
              + crl_pkg::ACC_W'(prod_ff[2]) + crl_pkg::ACC_W'(prod_ff[3])
              + crl_pkg::ACC_W'(longint'(1) << (crl_pkg::OUT_SHIFT - 1));
      acc_shift = acc_sum[crl_pkg::ACC_W-1:crl_pkg::OUT_SHIFT];
      if (acc_shift < crl_pkg::OUT_MIN) begin
         pixel_sat = crl_pkg::OUT_W'(crl_pkg::OUT_MIN);
      end else if (acc_shift > crl_pkg::OUT_MAX) begin
         pixel_sat = crl_pkg::OUT_W'(crl_pkg::OUT_MAX);
      end else begin
         pixel_sat = acc_shift[crl_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= '0;
         win1_ff <= '0;
         win2_ff <= '0;
         pos_ff  <= 2'd0;
      end else if (cmd.load) begin
         win0_ff <= pixel_in;
         win1_ff <= win0_in;
         win2_ff <= win1_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         snap_ff[0] <= win2_in;
         snap_ff[1] <= win1_in;
         snap_ff[2] <= win0_in;
         snap_ff[3] <= pixel_in;
      end
   end

   // the whole pipeline moves only when the output register frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int t = 0; t < crl_pkg::TAP_COUNT; t++) begin
            prod_ff[t] <= weight_rom[rom_idx][t] * $signed({1'b0, tap_sel[t]});
         end
         s1_last_ff   <= cmd.run_last;
         s1_done_ff   <= cmd.line_done;
         out_pixel_ff <= pixel_sat;
         out_last_ff  <= s1_last_ff;
         out_done_ff  <= s1_done_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_run_last  = out_last_ff;
   assign rsp_line_done = out_done_ff;

endmodule

### hdl/crl_controller.sv
// Controller: factor register and the sequencer that walks source positions
// and phases of each accepted pixel. Depends on crl_pkg; drives crl_datapath.
module crl_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [crl_pkg::FACTOR_W-1:0] csr_write_data,
   input  logic                         req_valid,
   input  logic                         req_line_end,
   output logic                         req_ready,
   input  crl_pkg::dp_sts_type          sts,
   output crl_pkg::ctl_cmd_type         cmd
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type                      state_ff, state_in;
   logic [crl_pkg::FACTOR_W-1:0]   factor_ff;
   crl_pkg::grp_type               grp_ff, grp_in;
   logic [crl_pkg::PHASE_IDX_W-1:0] phase_ff, phase_in;
   logic                           last_ff, last_in;

   logic [crl_pkg::EFF_W-1:0]       r_eff;
   logic [crl_pkg::PHASE_IDX_W-1:0] phase_end;
   logic                            issue, final_sample, accept, has_work;
   crl_pkg::grp_type                start_grp, end_grp;

   // factor zero acts as one; above the table size it saturates
   always_comb begin
      if (factor_ff == '0) begin
         r_eff = crl_pkg::EFF_W'(1);
      end else if (crl_pkg::EFF_W'(factor_ff) > crl_pkg::EFF_W'(crl_pkg::MAX_FACTOR)) begin
         r_eff = crl_pkg::EFF_W'(crl_pkg::MAX_FACTOR);
      end else begin
         r_eff = crl_pkg::EFF_W'(factor_ff);
      end
   end

   assign phase_end = crl_pkg::PHASE_IDX_W'(r_eff - crl_pkg::EFF_W'(1));

   always_comb begin
      end_grp      = last_ff ? crl_pkg::GRP_C : crl_pkg::GRP_A;
      final_sample = (grp_ff == end_grp) && (phase_ff == phase_end);
      issue        = (state_ff == RUN) && sts.advance;
      req_ready    = (state_ff == IDLE) || (issue && final_sample);
      accept       = req_valid && req_ready;
      has_work     = (sts.pos == 2'd2) || req_line_end;
      if (sts.pos == 2'd2) begin
         start_grp = crl_pkg::GRP_A;
      end else if (sts.pos == 2'd1) begin
         start_grp = crl_pkg::GRP_B;
      end else begin
         start_grp = crl_pkg::GRP_C;
      end
   end

   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      if (accept) begin
         state_in = has_work ? RUN : IDLE;
         grp_in   = start_grp;
         phase_in = '0;
         last_in  = req_line_end;
      end else if (issue && final_sample) begin
         state_in = IDLE;
      end else if (issue) begin
         if (phase_ff == phase_end) begin
            phase_in = '0;
            case (grp_ff)
               crl_pkg::GRP_A: grp_in = crl_pkg::GRP_B;
               default:        grp_in = crl_pkg::GRP_C;
            endcase
         end else begin
            phase_in = phase_ff + 1'b1;
         end
      end
   end

   always_comb begin
      cmd.load       = accept;
      cmd.issue      = issue;
      cmd.grp        = grp_ff;
      cmd.phase      = phase_ff;
      cmd.factor_idx = phase_end;
      cmd.run_last   = final_sample;
      cmd.line_done  = final_sample && last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         factor_ff <= crl_pkg::FACTOR_W'(crl_pkg::FACTOR_RESET);
         grp_ff    <= crl_pkg::GRP_A;
         phase_ff  <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         if (csr_write_enable) begin
            factor_ff <= csr_write_data;
         end
      end
   end

   // the clamped positions only occur at the end of a line
   a_grp_b_needs_last : assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN && grp_ff == crl_pkg::GRP_B) |-> last_ff)
      else $error("right-clamped position without line end");

   a_grp_c_needs_last : assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN && grp_ff == crl_pkg::GRP_C) |-> last_ff)
      else $error("flush position without line end");

   a_phase_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |-> (phase_ff <= phase_end))
      else $error("phase beyond factor");

   a_issue_then_ready : assert property (@(posedge clock) disable iff (reset)
      (issue && final_sample) |=> (state_ff == IDLE || $past(accept)))
      else $error("sequencer kept running after final sample");

endmodule

### hdl/catmull_rom_line_upsampler_unit.sv
// Catmull-Rom line upsampler, top level. Each accepted pixel emits zero to
// three source positions of R samples each (R = upscale factor, 1..8), one
// sample per cycle through a two-stage multiply/accumulate pipeline; results
// pass through the product register into the output register. An item with
// no results leaves the sequencer idle; otherwise the sequencer issues R
// samples for each position and the next pixel is taken in the cycle its last
// sample issues. The single sample issue slot sets the rate, and output stalls
// hold the whole pipeline. Depends on crl_pkg, crl_req_if, crl_rsp_if,
// crl_controller and crl_datapath.
module catmull_rom_line_upsampler_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [crl_pkg::FACTOR_W-1:0] csr_write_data,
   crl_req_if.sink                      req_if,
   crl_rsp_if.source                    rsp_if
);

   crl_pkg::ctl_cmd_type cmd;
   crl_pkg::dp_sts_type  sts;

   crl_controller u_ctl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_if.valid),
      .req_line_end     (req_if.line_end),
      .req_ready        (req_if.ready),
      .sts              (sts),
      .cmd              (cmd)
   );

   crl_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .pixel_in      (req_if.pixel_in),
      .line_end      (req_if.line_end),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_pixel_out (rsp_if.pixel_out),
      .rsp_run_last  (rsp_if.run_last),
      .rsp_line_done (rsp_if.line_done)
   );

endmodule

### bench/crl_upsample_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Catmull-Rom line upsampler: follows scale factor writes, predicts the
// interpolated samples of every accepted pixel and checks them against the result channel.
// Depends on crl_pkg, crl_req_if and crl_rsp_if.
module crl_upsample_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [crl_pkg::FACTOR_W-1:0] csr_write_data,
   crl_req_if                           req_if,
   crl_rsp_if                           rsp_if,
   output int                           fail_count,
   output int                           pending_count
);

   typedef struct packed {
      logic signed [crl_pkg::OUT_W-1:0] pixel_out;
      logic                             run_last;
      logic                             line_done;
   } sample_type;

   sample_type                   expected_samples[$];
   sample_type                   run_samples[$];
   logic [crl_pkg::PIXEL_W-1:0]  history[3];      // previous pixels, newest first
   logic [1:0]                   pixels_seen;
   logic [crl_pkg::FACTOR_W-1:0] factor_reg;
   int                           mismatches = 0;
   int                           sample_index = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // Q1.15 cubic weight for phase j/r; tap 0..3 covers offsets -2..+1
   function automatic longint phase_weight(longint j, longint r, int tap);
      longint num, den, mag, q;
      den = 2 * r * r * r;
      case (tap)
         0:       num = -j * (r - j) * (r - j);
         1:       num = 3 * j * j * j - 5 * j * j * r + 2 * r * r * r;
         2:       num = j * (r * r + 4 * j * r - 3 * j * j);
         default: num = j * j * (j - r);
      endcase
      num = num * (longint'(1) << crl_pkg::WEIGHT_FRAC_BITS);
      mag = (num < 0) ? -num : num;
      q   = (mag + den / 2) / den;       // nearest, ties away from zero
      return (num < 0) ? -q : q;
   endfunction

   task automatic emit_position(input longint t0, input longint t1, input longint t2,
                                input longint t3, input longint r);
      longint     acc;
      longint     j;
      sample_type s;
      for (j = 1; j <= r; j++) begin
         acc = phase_weight(j, r, 0) * t0 + phase_weight(j, r, 1) * t1
             + phase_weight(j, r, 2) * t2 + phase_weight(j, r, 3) * t3;
         acc = acc + (longint'(1) << (crl_pkg::WEIGHT_FRAC_BITS - 5));
         acc = acc >>> (crl_pkg::WEIGHT_FRAC_BITS - 4);
         if (acc < crl_pkg::OUT_MIN) acc = crl_pkg::OUT_MIN;
         if (acc > crl_pkg::OUT_MAX) acc = crl_pkg::OUT_MAX;
         s.pixel_out = acc[crl_pkg::OUT_W-1:0];
         s.run_last  = 1'b0;
         s.line_done = 1'b0;
         run_samples.push_back(s);
      end
   endtask

   task automatic predict_pixel(input logic [crl_pkg::PIXEL_W-1:0] px, input logic last);
      longint     r;
      longint     tap[6];
      sample_type s;
      int         n;
      r = factor_reg;
      if (r < 1) r = 1;
      if (r > crl_pkg::MAX_FACTOR) r = crl_pkg::MAX_FACTOR;
      // first pixel of a line fills the window, clamping the left edge
      if (pixels_seen == 2'd0) begin
         history[0] = px;
         history[1] = px;
         history[2] = px;
      end
      tap[0] = history[2];
      tap[1] = history[1];
      tap[2] = history[0];
      tap[3] = px;
      tap[4] = px;
      tap[5] = px;
      run_samples.delete();
      if (pixels_seen >= 2'd2) emit_position(tap[0], tap[1], tap[2], tap[3], r);
      if (last) begin
         if (pixels_seen >= 2'd1) emit_position(tap[1], tap[2], tap[3], tap[4], r);
         emit_position(tap[2], tap[3], tap[4], tap[5], r);
      end
      n = run_samples.size();
      if (n > 0) begin
         s = run_samples[n-1];
         s.run_last  = 1'b1;
         s.line_done = last;
         run_samples[n-1] = s;
      end
      foreach (run_samples[i]) expected_samples.push_back(run_samples[i]);
      history[2] = history[1];
      history[1] = history[0];
      history[0] = px;
      if (last) pixels_seen = 2'd0;
      else if (pixels_seen < 2'd2) pixels_seen = pixels_seen + 2'd1;
   endtask

   task automatic check_sample();
      sample_type want;
      if (expected_samples.size() == 0) begin
         report_mismatch($sformatf("sample %0d arrived with nothing expected (pixel_out %0d)",
                                   sample_index, rsp_if.pixel_out));
      end else begin
         want = expected_samples.pop_front();
         if (rsp_if.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("sample %0d pixel_out got %0d expected %0d",
                                      sample_index, rsp_if.pixel_out, want.pixel_out));
         if (rsp_if.run_last !== want.run_last)
            report_mismatch($sformatf("sample %0d run_last got %b expected %b",
                                      sample_index, rsp_if.run_last, want.run_last));
         if (rsp_if.line_done !== want.line_done)
            report_mismatch($sformatf("sample %0d line_done got %b expected %b",
                                      sample_index, rsp_if.line_done, want.line_done));
      end
      sample_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_samples.delete();
         history     = '{default: '0};
         pixels_seen = 2'd0;
         factor_reg  = crl_pkg::FACTOR_W'(crl_pkg::FACTOR_RESET);
      end else begin
         // results first: a pixel transfer never produces a sample at the same edge
         if (rsp_if.valid && rsp_if.ready) check_sample();
         if (req_if.valid && req_if.ready) predict_pixel(req_if.pixel_in, req_if.line_end);
         if (csr_write_enable) factor_reg = csr_write_data;
      end
      pending_count = expected_samples.size();
   end

endmodule

### bench/catmull_rom_line_upsampler_unit_tb.sv
`timescale 1ns / 100ps
// Top-level bench for the Catmull-Rom line upsampler: drives pixel lines and scale factor
// writes under varying backpressure. Depends on crl_pkg, the channel interfaces and the checker.
module catmull_rom_line_upsampler_unit_tb;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write_enable;
   logic [crl_pkg::FACTOR_W-1:0] csr_write_data;
   int                           send_idle_pct;
   int                           take_stall_pct;
   int                           fail_count;
   int                           pending_count;

   crl_req_if req_ch();
   crl_rsp_if rsp_ch();

   catmull_rom_line_upsampler_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch)
   );

   crl_upsample_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= take_stall_pct);
   end

   task automatic push_pixel(input logic [crl_pkg::PIXEL_W-1:0] px, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pixel_in <= px;
      req_ch.line_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // idle the input and wait until every predicted sample has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_factor(input logic [crl_pkg::FACTOR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_line(input int len);
      int                          style;
      logic [crl_pkg::PIXEL_W-1:0] px;
      style = $urandom_range(3);
      px    = 8'($urandom_range(255));
      for (int i = 0; i < len; i++) begin
         case (style)
            0, 1:    px = 8'($urandom_range(255));
            2:       px = $urandom_range(1) ? 8'hFF : 8'h00;
            default: px = 8'(px + $urandom_range(6) - 3);   // slow ramp
         endcase
         push_pixel(px, i == len - 1);
      end
   endtask

   initial begin
      int seg_items;
      int len;
      req_ch.valid     = 1'b0;
      req_ch.pixel_in  = '0;
      req_ch.line_end  = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      send_idle_pct    = 33;
      take_stall_pct   = 63;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset factor: one-pixel, two-pixel, three-pixel and longer lines at the extremes
      push_pixel(8'h00, 1'b1);
      push_pixel(8'hFF, 1'b1);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b1);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b1);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'h80, 1'b1);
      drain();
      set_factor(4'd8);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b0);
      push_pixel(8'hFF, 1'b1);
      drain();
      set_factor(4'd1);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b1);
      push_pixel(8'h00, 1'b1);
      drain();
      set_factor(4'd0);                     // zero factor behaves as one
      push_pixel(8'h00, 1'b0);
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b1);
      drain();
      set_factor(4'd15);                    // saturates to the largest factor
      push_pixel(8'hFF, 1'b0);
      push_pixel(8'h00, 1'b1);
      drain();

      for (int seg = 0; seg < 9; seg++) begin
         case (seg / 3)
            0:       begin send_idle_pct = 33; take_stall_pct = 63; end
            1:       begin send_idle_pct = 63; take_stall_pct = 33; end
            default: begin send_idle_pct = 0;  take_stall_pct = 0;  end
         endcase
         set_factor(4'($urandom_range(15)));
         seg_items = 0;
         while (seg_items < 19) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            send_line(len);
            seg_items += len;
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
hdl/crl_pkg.sv
hdl/crl_req_if.sv
hdl/crl_rsp_if.sv
hdl/crl_datapath.sv
hdl/crl_controller.sv
hdl/catmull_rom_line_upsampler_unit.sv
bench/crl_upsample_checker.sv
bench/catmull_rom_line_upsampler_unit_tb.sv
